### rtl/core/spk_pkg.sv
// spk_pkg: word types, beat structs, register indexes and rotate helpers
// for the speck128/128 cipher core; no dependencies
`timescale 1ns / 1ps

package spk_pkg;

  localparam int WORD_BITS    = 64;
  localparam int ROUNDS       = 32;
  localparam int RK_ADDR_BITS = $clog2(ROUNDS);
  localparam int ALPHA        = 8;
  localparam int BETA         = 3;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [WORD_BITS-1:0]    word_t;
  typedef logic [RK_ADDR_BITS-1:0] rk_addr_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam rk_addr_t LAST_ROUND = rk_addr_t'(ROUNDS - 1);

  localparam cfg_idx_t REG_KEY_WORD_0 = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_WORD_1 = cfg_idx_t'(1);

  typedef struct packed {
    logic  func;
    word_t block_x;
    word_t block_y;
  } req_t;

  typedef struct packed {
    word_t out_x;
    word_t out_y;
  } rsp_t;

  // round key store write side, driven by the key schedule
  typedef struct packed {
    logic     busy;
    logic     we;
    rk_addr_t addr;
    word_t    data;
  } key_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_DONE
  } seq_state_t;

  function automatic word_t rotr_alpha(input word_t v);
    return {v[ALPHA-1:0], v[WORD_BITS-1:ALPHA]};
  endfunction

  function automatic word_t rotl_alpha(input word_t v);
    return {v[WORD_BITS-ALPHA-1:0], v[WORD_BITS-1:WORD_BITS-ALPHA]};
  endfunction

  function automatic word_t rotr_beta(input word_t v);
    return {v[BETA-1:0], v[WORD_BITS-1:BETA]};
  endfunction

  function automatic word_t rotl_beta(input word_t v);
    return {v[WORD_BITS-BETA-1:0], v[WORD_BITS-1:WORD_BITS-BETA]};
  endfunction

endpackage

### rtl/core/spk_ram.sv
// spk_ram: generic single write port ram with registered read
// no package dependencies
`timescale 1ns / 1ps

module spk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/spk_key_sched.sv
// spk_key_sched: key word registers and the iterative key expansion,
// one round key written per cycle; depends on spk_pkg
`timescale 1ns / 1ps

module spk_key_sched
  import spk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  word_t    cfg_data,
  output key_wr_t  key_wr
);

  word_t    key_word_0;
  word_t    key_word_1;
  word_t    l;
  word_t    k;
  word_t    l_next;
  word_t    k_next;
  word_t    key0_new;
  word_t    key1_new;
  rk_addr_t cnt;
  logic     busy;
  logic     key_hit;

  assign key_hit  = cfg_we && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1);
  assign key0_new = (cfg_index == REG_KEY_WORD_0) ? cfg_data : key_word_0;
  assign key1_new = (cfg_index == REG_KEY_WORD_1) ? cfg_data : key_word_1;

  assign l_next = (k + rotr_alpha(l)) ^ {{(WORD_BITS-RK_ADDR_BITS){1'b0}}, cnt};
  assign k_next = rotl_beta(k) ^ l_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      busy       <= 1'b0;
      cnt        <= '0;
    end else if (key_hit) begin
      // any key write restarts the expansion
      key_word_0 <= key0_new;
      key_word_1 <= key1_new;
      busy       <= 1'b1;
      cnt        <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == LAST_ROUND) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_hit) begin
      l <= key0_new;
      k <= key1_new;
    end else if (busy) begin
      l <= l_next;
      k <= k_next;
    end
  end

  assign key_wr.busy = busy;
  assign key_wr.we   = busy;
  assign key_wr.addr = cnt;
  assign key_wr.data = k;

endmodule

### rtl/core/spk_round.sv
// spk_round: one arx round, forward or inverse, around a shared add/subtract
// depends on spk_pkg
`timescale 1ns / 1ps

module spk_round
  import spk_pkg::*;
(
  input  logic  dec,
  input  word_t x,
  input  word_t y,
  input  word_t rk,
  output word_t x_out,
  output word_t y_out
);

  word_t dec_y;
  word_t op_a;
  word_t op_b;
  word_t sum;
  word_t enc_x;

  assign dec_y = rotr_beta(x ^ y);
  assign op_a  = dec ? (x ^ rk) : rotr_alpha(x);
  assign op_b  = dec ? ~dec_y : y;
  // subtract as add of the complement plus one
  assign sum   = op_a + op_b + {{(WORD_BITS-1){1'b0}}, dec};
  assign enc_x = sum ^ rk;

  assign x_out = dec ? rotl_alpha(sum) : enc_x;
  assign y_out = dec ? dec_y : (rotl_beta(y) ^ enc_x);

endmodule

### rtl/core/speck128_128_block_cipher.sv
// speck128_128_block_cipher: top level with round sequencer, round key ram,
// key schedule and result register; depends on spk_pkg, spk_ram,
// spk_key_sched, spk_round
//
//   port group  | kind             | beat / write
//   req         | valid/ready in   | func, block_x, block_y
//   rsp         | valid/ready out  | out_x, out_y
//   cfg         | write enable     | key_word_0 (index 0), key_word_1 (index 1)
//
// an accepted block runs 32 rounds, one per cycle, each reading one round key
// from the single read port of the round key ram; the result register loads
// after the last round, once it is empty or being read; the next block is then taken in idle
// a key write runs the schedule over all 32 round keys, req_ready low meanwhile
// reset clears control and key words; round keys are undefined until a key write
// a stalled result waits in the result register while the next block is worked
`timescale 1ns / 1ps

module speck128_128_block_cipher
  import spk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  req_t     req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output rsp_t     rsp,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  word_t    cfg_data
);

  seq_state_t state;
  seq_state_t state_next;
  key_wr_t    key_wr;
  word_t      x;
  word_t      y;
  word_t      x_rnd;
  word_t      y_rnd;
  word_t      rk;
  logic       func_r;
  rk_addr_t   rnd_cnt;
  rk_addr_t   rd_cnt;
  rk_addr_t   rd_addr;
  logic       rd_dec;
  logic       accept;
  logic       rsp_load;

  spk_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_wr    (key_wr)
  );

  // decrypt walks the keys from the top, so the address is the inverted count
  assign rd_cnt  = (state == S_ROUND) ? rnd_cnt + 1'b1 : '0;
  assign rd_dec  = (state == S_ROUND) ? func_r : req.func;
  assign rd_addr = rd_dec ? ~rd_cnt : rd_cnt;

  spk_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROUNDS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (key_wr.we),
    .waddr (key_wr.addr),
    .wdata (key_wr.data),
    .raddr (rd_addr),
    .rdata (rk)
  );

  spk_round u_round (
    .dec   (func_r),
    .x     (x),
    .y     (y),
    .rk    (rk),
    .x_out (x_rnd),
    .y_out (y_rnd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !key_wr.busy;
        if (req_valid && !key_wr.busy) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd_cnt == LAST_ROUND) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_cnt <= '0;
    end else if (accept) begin
      rnd_cnt <= '0;
    end else if (state == S_ROUND) begin
      rnd_cnt <= rnd_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x      <= req.block_x;
      y      <= req.block_y;
      func_r <= req.func;
    end else if (state == S_ROUND) begin
      x <= x_rnd;
      y <= y_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.out_x <= x;
      rsp.out_y <= y;
    end
  end

  // no block is taken while the schedule fills the round key ram
  a_no_accept_in_sched: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !key_wr.busy)
    else $error("block taken during key expansion");

  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_ROUND && rnd_cnt == '0))
    else $error("accepted block did not start at round zero");

  a_last_round_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd_cnt == LAST_ROUND) |=> (state == S_DONE))
    else $error("sequencer missed the end of the rounds");

  a_key_write_expands: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1))
      |=> (key_wr.busy && key_wr.addr == '0))
    else $error("key write did not restart the schedule");

endmodule
